### hw/rtl/tsai_pkg.sv
// Shared types and constants for the timestamp align interpolator.
// Depends on nothing; imported by timestamp_align_interpolator.
package tsai_pkg;

    typedef enum logic [2:0] {
        ST_STORED    = 3'd0,
        ST_CORRECTED = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_LEAD_BIG  = 3'd3,
        ST_NO_PRED   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STORE,
        S_SCAN,
        S_MUL,
        S_DIV,
        S_FIN
    } fsm_t;

    // configuration register indexes
    localparam logic REG_JUMP_THR = 1'b0;
    localparam logic REG_MAX_LEAD = 1'b1;

    localparam logic [29:0] JUMP_THR_RST = 30'd5000000;
    localparam logic [29:0] MAX_LEAD_RST = 30'd10010000;

    localparam int TW = 62;           // time field width
    localparam int PW = 2 * TW;       // product width
    localparam int HW = TW / 2;       // partial product operand width

endpackage

### hw/rtl/timestamp_align_interpolator.sv
// Timestamp align interpolator: top level, table memory, delay check, divider.
// Depends on tsai_pkg.
//
// Aligns device timestamps to host time. A store word (tuser 0) appends a
// (device, host) pair to a circular table of TABLE_DEPTH entries held in one
// synchronous memory, flags a sequence gap and a delay jump against the upper
// median of the previous DELAY_WINDOW-1 delays, and latches a sticky fault.
// A correct word (tuser 1) scans the table oldest first, one entry per cycle
// through the memory read port, for the first entry later than the query,
// then interpolates host time between that entry and its predecessor with a
// 62x62 multiply in four 31x31 partial products and a restoring divide that
// retires one quotient bit per cycle. A store word passes through S_STORE and
// S_FIN before its result is registered. A correct word goes straight to S_FIN
// on an empty table; otherwise it scans in S_SCAN and then either is dropped
// to S_FIN or is interpolated through S_MUL and S_DIV before S_FIN. The input
// accepts again in the cycle after the result is registered, and a stall on
// the output holds the word in S_FIN.
// One word is in flight at a time; a finished result waits in the output
// register while the next input word is accepted. No clearing pass follows
// reset: only entries already written are ever read.
module timestamp_align_interpolator #(
    parameter int TABLE_DEPTH  = 128,
    parameter int DELAY_WINDOW = 5
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [29:0]                    cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [61:0] device_time_ns, [123:62] host_time_ns, [155:124] sample_seq, zero pad
    input  logic [159:0]                   s_axis_tdata,
    // [0] action
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [61:0] corrected_time_ns, [62] seq_gap, [63] delay_jump, [64] fault_latched, zero pad
    output logic [71:0]                    m_axis_tdata,
    // [2:0] status
    output tsai_pkg::status_t              m_axis_tuser
);
    import tsai_pkg::*;

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int NW  = DELAY_WINDOW - 1;       // delays kept for the median
    localparam int MED = NW / 2;                 // upper median position
    localparam int DCW = $clog2(DELAY_WINDOW + 1);
    localparam int RW  = $clog2(DELAY_WINDOW) + 1;
    localparam int DVW = $clog2(PW + 1);

    // wrap head + k into the circular table
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h, input logic [CW-1:0] k);
        logic [CW:0] s;
        s = (CW + 1)'(h) + (CW + 1)'(k);
        if (s >= (CW + 1)'(TABLE_DEPTH))
        begin
            s = s - (CW + 1)'(TABLE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // ---------------------------------------------------------------- state
    fsm_t                 state_reg, state_next;
    logic [29:0]          thr_reg, lead_max_reg;
    logic [AW-1:0]        head_reg, head_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        scan_k_reg, scan_k_next;
    logic [CW-1:0]        chk_k_reg, chk_k_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic signed [62:0]   dhist_reg [DELAY_WINDOW];
    logic signed [62:0]   dhist_next [DELAY_WINDOW];
    logic [DCW-1:0]       dcnt_reg, dcnt_next;
    logic [31:0]          last_seq_reg, last_seq_next;
    logic                 seq_vld_reg, seq_vld_next;
    logic                 fault_reg, fault_next;

    // latched input word
    logic                 act_reg, act_next;
    logic [TW-1:0]        q_reg, q_next;
    logic [TW-1:0]        hin_reg, hin_next;
    logic [31:0]          seq_reg, seq_next;

    // interpolation datapath
    logic [TW-1:0]        prev_d_reg, prev_d_next;
    logic [TW-1:0]        prev_h_reg, prev_h_next;
    logic [TW-1:0]        a_reg, a_next;
    logic [TW-1:0]        b_reg, b_next;
    logic [TW-1:0]        div_d_reg, div_d_next;
    logic [TW-1:0]        base_reg, base_next;
    logic                 neg_reg, neg_next;
    logic [1:0]           mstep_reg, mstep_next;
    logic [PW-1:0]        num_reg, num_next;
    logic [TW-1:0]        rem_reg, rem_next;
    logic [DVW-1:0]       dvcnt_reg, dvcnt_next;

    // pending result and output register
    status_t              r_status_reg, r_status_next;
    logic                 r_gap_reg, r_gap_next;
    logic                 r_jump_reg, r_jump_next;
    logic                 m_valid_reg, m_valid_next;
    status_t              m_status_reg, m_status_next;
    logic [TW-1:0]        m_time_reg, m_time_next;
    logic                 m_gap_reg, m_gap_next;
    logic                 m_jump_reg, m_jump_next;
    logic                 m_fault_reg, m_fault_next;

    // ---------------------------------------------------------------- memory
    logic [PW-1:0]        tmem [TABLE_DEPTH];
    logic [PW-1:0]        rd_data_reg;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    logic [TW-1:0]        rd_d, rd_h;

    assign rd_addr = slot_of(head_reg, scan_k_reg);
    assign wr_en   = (state_reg == S_STORE);
    assign wr_addr = (cnt_reg < CW'(TABLE_DEPTH)) ? slot_of(head_reg, cnt_reg) : head_reg;
    assign rd_d    = rd_data_reg[TW-1:0];
    assign rd_h    = rd_data_reg[PW-1:TW];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tmem[wr_addr] <= {hin_reg, q_reg};
        end
        rd_data_reg <= tmem[rd_addr];
    end

    // ---------------------------------------------------------------- handshakes
    logic in_acc, out_free;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {7'd0, m_fault_reg, m_jump_reg, m_gap_reg, m_time_reg};

    // ---------------------------------------------------------------- delay check
    logic signed [62:0] new_delay;
    logic signed [62:0] med;
    logic signed [63:0] dev_diff;
    logic [63:0]        abs_diff;
    logic               win_full;
    logic [RW-1:0]      rank [NW];

    assign new_delay = $signed({1'b0, q_reg}) - $signed({1'b0, hin_reg});
    assign win_full  = (dcnt_reg == DCW'(DELAY_WINDOW));

    // stable rank of each kept delay; the one ranked MED is the upper median
    always_comb
    begin
        med = '0;
        for (int i = 0; i < NW; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < NW; j++)
            begin
                if ((dhist_reg[j+1] < dhist_reg[i+1]) ||
                    ((j < i) && (dhist_reg[j+1] == dhist_reg[i+1])))
                begin
                    rank[i] = rank[i] + RW'(1);
                end
            end
        end
        for (int i = 0; i < NW; i++)
        begin
            if (rank[i] == RW'(MED))
            begin
                med = dhist_reg[i+1];
            end
        end
    end

    assign dev_diff = 64'(med) - 64'(new_delay);
    assign abs_diff = dev_diff[63] ? 64'(-dev_diff) : 64'(dev_diff);

    // ---------------------------------------------------------------- scan decisions
    logic          hit, lead_bad, scan_out;
    logic [TW-1:0] lead;
    assign hit      = chk_vld_reg && (rd_d > q_reg);
    assign lead     = rd_d - q_reg;
    assign lead_bad = lead > TW'(lead_max_reg);
    assign scan_out = !chk_vld_reg && (scan_k_reg == cnt_reg);

    // ---------------------------------------------------------------- divider step
    logic [TW:0] trial;
    logic        trial_ge;
    assign trial    = {rem_reg, num_reg[PW-1]};
    assign trial_ge = trial >= {1'b0, div_d_reg};

    // ---------------------------------------------------------------- multiplier step
    logic [HW-1:0] pa, pb;
    logic [TW-1:0] pp;
    logic [6:0]    psh;
    assign pa  = mstep_reg[1] ? a_reg[TW-1:HW] : a_reg[HW-1:0];
    assign pb  = mstep_reg[0] ? b_reg[TW-1:HW] : b_reg[HW-1:0];
    assign pp  = TW'(pa) * TW'(pb);
    assign psh = 7'(HW) * (7'(mstep_reg[1]) + 7'(mstep_reg[0]));

    logic [TW-1:0] interp;
    assign interp = neg_reg ? (base_reg - num_reg[TW-1:0]) : (base_reg + num_reg[TW-1:0]);

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (!s_axis_tuser)
                    begin
                        state_next = S_STORE;
                    end
                    else if (cnt_reg == '0)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_STORE: state_next = S_FIN;
            S_SCAN:
            begin
                if (hit)
                begin
                    state_next = (lead_bad || chk_k_reg == '0) ? S_FIN : S_MUL;
                end
                else if (scan_out)
                begin
                    state_next = S_FIN;
                end
            end
            S_MUL:
            begin
                if (mstep_reg == 2'd3)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (dvcnt_reg == DVW'(1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- datapath
    always_comb
    begin
        head_next     = head_reg;
        cnt_next      = cnt_reg;
        scan_k_next   = scan_k_reg;
        chk_k_next    = chk_k_reg;
        chk_vld_next  = chk_vld_reg;
        dhist_next    = dhist_reg;
        dcnt_next     = dcnt_reg;
        last_seq_next = last_seq_reg;
        seq_vld_next  = seq_vld_reg;
        fault_next    = fault_reg;
        act_next      = act_reg;
        q_next        = q_reg;
        hin_next      = hin_reg;
        seq_next      = seq_reg;
        prev_d_next   = prev_d_reg;
        prev_h_next   = prev_h_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        div_d_next    = div_d_reg;
        base_next     = base_reg;
        neg_next      = neg_reg;
        mstep_next    = mstep_reg;
        num_next      = num_reg;
        rem_next      = rem_reg;
        dvcnt_next    = dvcnt_reg;
        r_status_next = r_status_reg;
        r_gap_next    = r_gap_reg;
        r_jump_next   = r_jump_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_status_next = m_status_reg;
        m_time_next   = m_time_reg;
        m_gap_next    = m_gap_reg;
        m_jump_next   = m_jump_reg;
        m_fault_next  = m_fault_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    act_next      = s_axis_tuser;
                    q_next        = s_axis_tdata[61:0];
                    hin_next      = s_axis_tdata[123:62];
                    seq_next      = s_axis_tdata[155:124];
                    scan_k_next   = '0;
                    chk_vld_next  = 1'b0;
                    r_gap_next    = 1'b0;
                    r_jump_next   = 1'b0;
                    r_status_next = s_axis_tuser ? ST_EMPTY : ST_STORED;
                end
            end
            S_STORE:
            begin
                r_gap_next    = seq_vld_reg && (seq_reg != last_seq_reg + 32'd1);
                r_jump_next   = win_full && (abs_diff > 64'(thr_reg));
                last_seq_next = seq_reg;
                seq_vld_next  = 1'b1;
                if (cnt_reg < CW'(TABLE_DEPTH))
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                else
                begin
                    head_next = slot_of(head_reg, CW'(1));
                end
                // drop the oldest delay once the window is full, then append
                if (win_full)
                begin
                    for (int i = 0; i < NW; i++)
                    begin
                        dhist_next[i] = dhist_reg[i+1];
                    end
                    dhist_next[NW] = new_delay;
                end
                else
                begin
                    dhist_next[dcnt_reg[DCW-1:0]] = new_delay;
                    dcnt_next = dcnt_reg + DCW'(1);
                end
                if (r_gap_next || r_jump_next)
                begin
                    fault_next = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    if (lead_bad)
                    begin
                        r_status_next = ST_LEAD_BIG;
                    end
                    else if (chk_k_reg == '0)
                    begin
                        r_status_next = ST_NO_PRED;
                    end
                    else
                    begin
                        r_status_next = ST_CORRECTED;
                        neg_next      = rd_h < prev_h_reg;
                        a_next        = (rd_h < prev_h_reg) ? (prev_h_reg - rd_h)
                                                            : (rd_h - prev_h_reg);
                        b_next        = q_reg - prev_d_reg;
                        div_d_next    = rd_d - prev_d_reg;
                        base_next     = prev_h_reg;
                        mstep_next    = '0;
                        num_next      = '0;
                        // discard entries older than the predecessor
                        head_next     = slot_of(head_reg, chk_k_reg - CW'(1));
                        cnt_next      = cnt_reg - (chk_k_reg - CW'(1));
                    end
                end
                else if (scan_out)
                begin
                    r_status_next = ST_NO_PRED;
                end
                else
                begin
                    if (chk_vld_reg)
                    begin
                        prev_d_next = rd_d;
                        prev_h_next = rd_h;
                    end
                    if (scan_k_reg < cnt_reg)
                    begin
                        chk_vld_next = 1'b1;
                        chk_k_next   = scan_k_reg;
                        scan_k_next  = scan_k_reg + CW'(1);
                    end
                    else
                    begin
                        chk_vld_next = 1'b0;
                    end
                end
            end
            S_MUL:
            begin
                num_next   = num_reg + (PW'(pp) << psh);
                mstep_next = mstep_reg + 2'd1;
                rem_next   = '0;
                dvcnt_next = DVW'(PW);
            end
            S_DIV:
            begin
                rem_next   = trial_ge ? TW'(trial - {1'b0, div_d_reg}) : trial[TW-1:0];
                num_next   = {num_reg[PW-2:0], trial_ge};
                dvcnt_next = dvcnt_reg - DVW'(1);
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = r_status_reg;
                    m_time_next   = (r_status_reg == ST_CORRECTED) ? interp : '0;
                    m_gap_next    = r_gap_reg;
                    m_jump_next   = r_jump_reg;
                    m_fault_next  = fault_reg;
                end
            end
            default:
            begin
                m_valid_next = m_valid_reg;
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            thr_reg      <= JUMP_THR_RST;
            lead_max_reg <= MAX_LEAD_RST;
            head_reg     <= '0;
            cnt_reg      <= '0;
            scan_k_reg   <= '0;
            chk_k_reg    <= '0;
            chk_vld_reg  <= 1'b0;
            dcnt_reg     <= '0;
            last_seq_reg <= '0;
            seq_vld_reg  <= 1'b0;
            fault_reg    <= 1'b0;
            mstep_reg    <= '0;
            dvcnt_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            cnt_reg      <= cnt_next;
            scan_k_reg   <= scan_k_next;
            chk_k_reg    <= chk_k_next;
            chk_vld_reg  <= chk_vld_next;
            dcnt_reg     <= dcnt_next;
            last_seq_reg <= last_seq_next;
            seq_vld_reg  <= seq_vld_next;
            fault_reg    <= fault_next;
            mstep_reg    <= mstep_next;
            dvcnt_reg    <= dvcnt_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we && cfg_index == REG_JUMP_THR)
            begin
                thr_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == REG_MAX_LEAD)
            begin
                lead_max_reg <= cfg_wdata;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        dhist_reg    <= dhist_next;
        act_reg      <= act_next;
        q_reg        <= q_next;
        hin_reg      <= hin_next;
        seq_reg      <= seq_next;
        prev_d_reg   <= prev_d_next;
        prev_h_reg   <= prev_h_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        div_d_reg    <= div_d_next;
        base_reg     <= base_next;
        neg_reg      <= neg_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        r_status_reg <= r_status_next;
        r_gap_reg    <= r_gap_next;
        r_jump_reg   <= r_jump_next;
        m_status_reg <= m_status_next;
        m_time_reg   <= m_time_next;
        m_gap_reg    <= m_gap_next;
        m_jump_reg   <= m_jump_next;
        m_fault_reg  <= m_fault_next;
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(TABLE_DEPTH))
        else $error("table count beyond depth");

    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        fault_reg |=> fault_reg)
        else $error("fault cleared");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_d_reg != '0 && act_reg))
        else $error("divide by zero or on a store word");
`endif

endmodule
